// ----- hdl/assert_macros.svh -----
// shared assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hdl/lpht_pkg.sv -----
package lpht_pkg;

   localparam int KEY_W      = 64;
   localparam int DATA_W     = 32;
   localparam int SLOT_W     = 5;
   localparam int KEY_BYTES  = 8;
   localparam int BYTES_MAX  = 8;
   // byte sum of eight bytes fits in 11 bits
   localparam int SUM_W      = 11;
   localparam int HASH_STEPS = 2;
   localparam int HCNT_W     = 1;
   // byte sum times its reciprocal constant
   localparam int WIDE_W     = 2 * SUM_W + 1;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_EDIT   = 2'd2;
   localparam logic [1:0] KIND_SEARCH = 2'd3;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_MISSING = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_EMPTY   = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [KEY_W-1:0]  key_chars;
      logic [KEY_W-1:0]  new_key_chars;
      logic [DATA_W-1:0] record_data;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] found_data;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic hash;
      logic probe;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic req_empty;
      logic clear_last;
      logic hash_last;
      logic hit;
      logic miss;
   } sts_type;

endpackage

// ----- hdl/linear_probe_hash_table.sv -----
// hash table of SLOTS entries keyed by strings of up to eight bytes
// req channel (req_valid/req_ready/req_item): one operation per item,
//   insert, remove, edit or search, with key, replacement key and payload
// rsp channel (rsp_valid/rsp_ready/rsp_item): exactly one result per item,
//   status, slot index and found payload, in request order
// steps: empty keys go from accept straight to the result stage; otherwise a
//   reciprocal multiply finds the home slot, then probing reads one slot per
//   cycle through the single read port of the key and occupancy memories, then
//   the result moves into the output register
// flow: one item in flight; the next item can be taken in the cycle after the
//   result moves into the output register
// reset: req_ready stays low while the occupancy memory is swept to empty; key
//   and payload memories are not cleared
// stall: a result waits in the output register while rsp_ready is low; a new
//   item may still be accepted, and its result waits until the register frees
module linear_probe_hash_table #(
   parameter int SLOTS = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpht_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpht_pkg::rsp_type rsp_item
);

   lpht_pkg::cmd_type cmd;
   lpht_pkg::sts_type sts;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpht_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule

// ----- hdl/lpht_dpath.sv -----
`include "assert_macros.svh"

module lpht_dpath #(
   parameter int SLOTS = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  lpht_pkg::req_type req_item,
   input  lpht_pkg::cmd_type cmd,
   output lpht_pkg::sts_type sts,
   output lpht_pkg::rsp_type rsp_item
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // reciprocal of SLOTS rounded up, exact for every byte sum
   localparam int RECIP_SH = lpht_pkg::SUM_W + $clog2(SLOTS);
   localparam int RECIP_M  = ((1 << RECIP_SH) + SLOTS - 1) / SLOTS;

   // keep bytes up to the first zero byte, at most KEY_BYTES of them
   function automatic logic [lpht_pkg::KEY_W-1:0] norm_key(
      input logic [lpht_pkg::KEY_W-1:0] raw
   );
      logic [lpht_pkg::KEY_W-1:0] k;
      logic                       live;
      k    = '0;
      live = 1'b1;
      for (int i = 0; i < lpht_pkg::BYTES_MAX; i++) begin
         live = live && (raw[8*i +: 8] != 8'd0) && (i < lpht_pkg::KEY_BYTES);
         if (live) begin
            k[8*i +: 8] = raw[8*i +: 8];
         end
      end
      return k;
   endfunction

   // stores
   logic [lpht_pkg::KEY_W-1:0]  key_mem [SLOTS];
   logic [lpht_pkg::DATA_W-1:0] pay_mem [SLOTS];
   logic                        occ_mem [SLOTS];

   // item registers
   logic [1:0]                  kind_ff;
   logic [lpht_pkg::KEY_W-1:0]  key_ff, nkey_ff;
   logic [lpht_pkg::DATA_W-1:0] data_ff;

   // hash and probe state
   logic [lpht_pkg::SUM_W-1:0]  rem_ff, rem_in;
   logic [lpht_pkg::SUM_W-1:0]  quot_ff, quot_in;
   logic [lpht_pkg::HCNT_W-1:0] hcnt_ff, hcnt_in;
   logic [IDX_W-1:0]            rd_addr_ff, rd_addr_in, rd_addr_nx;
   logic [CNT_W-1:0]            icnt_ff, icnt_in;
   logic                        chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]            chk_addr_ff;

   // registered read data
   logic [lpht_pkg::KEY_W-1:0]  key_q_ff;
   logic [lpht_pkg::DATA_W-1:0] pay_q_ff;
   logic                        occ_q_ff;

   lpht_pkg::rsp_type res_ff, res_in;
   lpht_pkg::rsp_type rsp_ff;

   logic [lpht_pkg::KEY_W-1:0]  req_key, req_nkey;
   logic [lpht_pkg::SUM_W-1:0]  req_sum;
   logic [lpht_pkg::WIDE_W-1:0] quot_prod, back_prod;
   logic [lpht_pkg::SUM_W-1:0]  home_idx;
   logic                        issue, match, hit, miss;
   logic [IDX_W-1:0]            wr_addr;
   logic                        key_we, occ_we, occ_wdata;
   logic [lpht_pkg::KEY_W-1:0]  key_wdata;

   always_comb begin
      req_key  = norm_key(req_item.key_chars);
      req_nkey = norm_key(req_item.new_key_chars);
      req_sum  = '0;
      for (int i = 0; i < lpht_pkg::BYTES_MAX; i++) begin
         req_sum = req_sum + lpht_pkg::SUM_W'(req_key[8*i +: 8]);
      end
   end

   assign sts.req_empty = (req_key == '0) ||
                          ((req_item.kind == lpht_pkg::KIND_EDIT) && (req_nkey == '0));

   // home slot: quotient by reciprocal multiply, remainder the cycle after
   assign quot_prod = lpht_pkg::WIDE_W'(rem_ff) * lpht_pkg::WIDE_W'(RECIP_M);
   assign quot_in   = lpht_pkg::SUM_W'(quot_prod >> RECIP_SH);
   assign back_prod = lpht_pkg::WIDE_W'(quot_ff) * lpht_pkg::WIDE_W'(SLOTS);
   assign home_idx  = lpht_pkg::SUM_W'(lpht_pkg::WIDE_W'(rem_ff) - back_prod);

   assign sts.hash_last  = (hcnt_ff == lpht_pkg::HCNT_W'(lpht_pkg::HASH_STEPS - 1));
   assign sts.clear_last = (rd_addr_ff == IDX_W'(SLOTS - 1));

   assign rd_addr_nx = sts.clear_last ? '0 : rd_addr_ff + 1'b1;

   // one read issued per cycle, checked the cycle after
   assign issue = cmd.probe && (icnt_ff != CNT_W'(SLOTS));
   assign match = (kind_ff == lpht_pkg::KIND_INSERT) ? !occ_q_ff :
                  (occ_q_ff && (key_q_ff == key_ff));
   assign hit   = cmd.probe && chk_valid_ff && match;
   assign miss  = cmd.probe && chk_valid_ff && !match && (icnt_ff == CNT_W'(SLOTS));

   assign sts.hit  = hit;
   assign sts.miss = miss;

   assign wr_addr   = cmd.clear ? rd_addr_ff : chk_addr_ff;
   assign key_we    = hit && ((kind_ff == lpht_pkg::KIND_INSERT) ||
                              (kind_ff == lpht_pkg::KIND_EDIT));
   assign key_wdata = (kind_ff == lpht_pkg::KIND_EDIT) ? nkey_ff : key_ff;
   assign occ_we    = cmd.clear || (hit && ((kind_ff == lpht_pkg::KIND_INSERT) ||
                                            (kind_ff == lpht_pkg::KIND_REMOVE)));
   assign occ_wdata = hit && (kind_ff == lpht_pkg::KIND_INSERT);

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_wdata;
         pay_mem[wr_addr] <= data_ff;
      end
      if (issue) begin
         key_q_ff <= key_mem[rd_addr_ff];
         pay_q_ff <= pay_mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[wr_addr] <= occ_wdata;
      end
      if (issue) begin
         occ_q_ff <= occ_mem[rd_addr_ff];
      end
   end

   always_comb begin
      rem_in       = rem_ff;
      hcnt_in      = hcnt_ff;
      rd_addr_in   = rd_addr_ff;
      icnt_in      = icnt_ff;
      chk_valid_in = 1'b0;
      res_in       = res_ff;
      if (cmd.clear) begin
         rd_addr_in = rd_addr_nx;
      end else if (cmd.load) begin
         rem_in            = req_sum;
         hcnt_in           = '0;
         res_in.status     = lpht_pkg::STAT_EMPTY;
         res_in.slot       = '0;
         res_in.found_data = '0;
      end else if (cmd.hash) begin
         hcnt_in = hcnt_ff + 1'b1;
         if (sts.hash_last) begin
            rd_addr_in = IDX_W'(home_idx);
            icnt_in    = '0;
         end
      end else if (cmd.probe) begin
         chk_valid_in = issue;
         if (issue) begin
            rd_addr_in = rd_addr_nx;
            icnt_in    = icnt_ff + 1'b1;
         end
         if (hit) begin
            res_in.status     = lpht_pkg::STAT_DONE;
            res_in.slot       = lpht_pkg::SLOT_W'(chk_addr_ff);
            res_in.found_data = (kind_ff == lpht_pkg::KIND_SEARCH) ? pay_q_ff : '0;
         end else if (miss) begin
            res_in.status     = (kind_ff == lpht_pkg::KIND_INSERT) ?
                                lpht_pkg::STAT_FULL : lpht_pkg::STAT_MISSING;
            res_in.slot       = '0;
            res_in.found_data = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcnt_ff      <= '0;
         rd_addr_ff   <= '0;
         icnt_ff      <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         hcnt_ff      <= hcnt_in;
         rd_addr_ff   <= rd_addr_in;
         icnt_ff      <= icnt_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      res_ff  <= res_in;
      if (issue) begin
         chk_addr_ff <= rd_addr_ff;
      end
      if (cmd.load) begin
         kind_ff <= req_item.kind;
         key_ff  <= req_key;
         nkey_ff <= req_nkey;
         data_ff <= req_item.record_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_item = rsp_ff;

   `ASSERT_NEVER(a_icnt_range, clock, reset, icnt_ff > CNT_W'(SLOTS), "probe count past table size")
   `ASSERT_NEVER(a_addr_range, clock, reset, rd_addr_ff > IDX_W'(SLOTS - 1), "probe address out of table")
   `ASSERT_CLK(a_hash_to_probe, clock, reset, (cmd.hash && sts.hash_last) |=> (icnt_ff == '0 && !chk_valid_ff), "probe not restarted after hash")

endmodule

// ----- hdl/lpht_ctrl.sv -----
`include "assert_macros.svh"

module lpht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  lpht_pkg::sts_type sts,
   output lpht_pkg::cmd_type cmd
);

   lpht_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         lpht_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = lpht_pkg::ST_IDLE;
            end
         end
         lpht_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.req_empty ? lpht_pkg::ST_RESP : lpht_pkg::ST_HASH;
            end
         end
         lpht_pkg::ST_HASH: begin
            cmd.hash = 1'b1;
            if (sts.hash_last) begin
               state_in = lpht_pkg::ST_PROBE;
            end
         end
         lpht_pkg::ST_PROBE: begin
            cmd.probe = 1'b1;
            if (sts.hit || sts.miss) begin
               state_in = lpht_pkg::ST_RESP;
            end
         end
         lpht_pkg::ST_RESP: begin
            // output register must be free before the result moves in
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = lpht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpht_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLK(a_accept_busy, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready after accept")
   `ASSERT_CLK(a_load_shows, clock, reset, cmd.rsp_load |=> rsp_valid_ff, "loaded result not shown")
   `ASSERT_NEVER(a_load_overrun, clock, reset, cmd.rsp_load && rsp_valid_ff && !rsp_ready, "result overwritten")

endmodule
